[rtl/core/five_point_smoothing_filter_core_assert.svh]
// ----------------------------------------------------------------------------
// Five-point smoothing filter: assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIVE_POINT_SMOOTHING_FILTER_CORE_ASSERT_SVH
`define FIVE_POINT_SMOOTHING_FILTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define FPSF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpsf: same-cycle check failed");

// Next-cycle implication.
`define FPSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpsf: next-cycle check failed");

`endif

[rtl/core/fpsf_pkg.sv]
// ----------------------------------------------------------------------------
// fpsf_pkg
// Types, tap table and arithmetic constants shared by the smoothing filter.
// ----------------------------------------------------------------------------
package fpsf_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int NUM_CELLS    = 5;
	localparam int COEF_W       = 8;
	// Tap products and their sum: |sum| <= 84 * 2^(SAMPLE_WIDTH-1)
	localparam int NUM_W        = SAMPLE_WIDTH + COEF_W;
	// Rounded magnitude before the divide, below 2^(SAMPLE_WIDTH+6)
	localparam int MAG_W        = SAMPLE_WIDTH + 6;
	localparam int RECIP_W      = MAG_W - 5;
	localparam int PROD_W       = MAG_W + RECIP_W;
	localparam int CUR_W        = 3;
	localparam int SEEN_W       = 3;

	localparam int DIVISOR  = 35;
	localparam int HALF_35  = 17;
	localparam int HALF_70  = 35;
	localparam logic [RECIP_W-1:0] RECIP_35 = RECIP_W'((64'd1 << MAG_W) / 64'd35);

	localparam logic [SEEN_W-1:0] SEEN_WINDOW = SEEN_W'(4);
	localparam logic [SEEN_W-1:0] SEEN_FULL   = SEEN_W'(5);

	// Result positions of a smoothing burst, oldest to newest
	localparam logic [CUR_W-1:0] POS_EDGE0 = CUR_W'(0);
	localparam logic [CUR_W-1:0] POS_EDGE1 = CUR_W'(1);
	localparam logic [CUR_W-1:0] POS_MID   = CUR_W'(2);
	localparam logic [CUR_W-1:0] POS_EDGE3 = CUR_W'(3);
	localparam logic [CUR_W-1:0] POS_EDGE4 = CUR_W'(4);
	localparam logic [CUR_W-1:0] CELL_NEWEST = CUR_W'(NUM_CELLS - 1);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]       coef_t;
	typedef logic signed [NUM_W-1:0]        num_t;

	localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
	localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
	localparam logic [MAG_W-1:0] MAG_POS_MAX = MAG_W'((64'd1 << (SAMPLE_WIDTH-1)) - 64'd1);
	localparam logic [MAG_W-1:0] MAG_NEG_MAX = MAG_W'(64'd1 << (SAMPLE_WIDTH-1));

	typedef enum logic [1:0] {
		DEN_ONE,
		DEN_35,
		DEN_70
	} den_t;

	typedef struct packed {
		logic valid;
		den_t den;
		logic eob;
	} ctrl_t;

	typedef struct packed {
		logic             busy;
		logic             pass;
		logic [CUR_W-1:0] cursor;
		logic             eob;
	} issue_t;

	// Rows: burst position; columns: cell 0 (oldest) to cell 4 (newest)
	localparam coef_t TAPS [NUM_CELLS][NUM_CELLS] = '{
		'{coef_t'(69), coef_t'(4),  coef_t'(-6), coef_t'(4),  coef_t'(-1)},
		'{coef_t'(2),  coef_t'(27), coef_t'(12), coef_t'(-8), coef_t'(2)},
		'{coef_t'(-3), coef_t'(12), coef_t'(17), coef_t'(12), coef_t'(-3)},
		'{coef_t'(2),  coef_t'(-8), coef_t'(12), coef_t'(27), coef_t'(2)},
		'{coef_t'(-1), coef_t'(4),  coef_t'(-6), coef_t'(4),  coef_t'(69)}
	};

	function automatic coef_t tap_coef(logic pass, logic [CUR_W-1:0] cursor,
			logic [CUR_W-1:0] cell_idx);
		coef_t c;
		c = '0;
		if (pass) begin
			if (cursor == cell_idx) c = coef_t'(1);
		end else if (cursor <= POS_EDGE4 && cell_idx <= CELL_NEWEST) begin
			c = TAPS[cursor][cell_idx];
		end
		return c;
	endfunction

	function automatic den_t den_of(logic pass, logic [CUR_W-1:0] cursor);
		den_t d;
		if (pass) d = DEN_ONE;
		else if (cursor == POS_EDGE0 || cursor == POS_EDGE4) d = DEN_70;
		else d = DEN_35;
		return d;
	endfunction

endpackage

[rtl/core/fpsf_cell.sv]
// ----------------------------------------------------------------------------
// fpsf_cell
// One window cell: holds a sample, passes it on, forms its tap product.
// ----------------------------------------------------------------------------
module fpsf_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  logic             adv,
	input  fpsf_pkg::sample_t sample_in,
	input  fpsf_pkg::coef_t   coef,
	output fpsf_pkg::sample_t held,
	output fpsf_pkg::num_t    prod
);
	import fpsf_pkg::*;

	sample_t held_q;
	num_t    prod_s1;

	// take the newer neighbor's sample (the input sample at the head cell) on every accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (shift_en) begin
			held_q <= sample_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= num_t'(coef) * num_t'(held_q);
		end
	end

	assign held = held_q;
	assign prod = prod_s1;

endmodule

[rtl/core/fpsf_seq.sv]
// ----------------------------------------------------------------------------
// fpsf_seq
// Block position counter and result burst sequencer.
// ----------------------------------------------------------------------------
`include "five_point_smoothing_filter_core_assert.svh"

module fpsf_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last,
	input  logic             adv,
	output logic             in_stall,
	output logic             shift_en,
	output fpsf_pkg::issue_t issue
);
	import fpsf_pkg::*;

	logic              busy_q;
	logic              pass_q;
	logic              last_q;
	logic [CUR_W-1:0]  cursor_q;
	logic [CUR_W-1:0]  stop_q;
	logic [SEEN_W-1:0] seen_q;
	logic              at_end;
	logic              accept;

	always_comb begin
		at_end   = (cursor_q == stop_q);
		in_stall = busy_q && !(at_end && adv);
		accept   = in_valid && !in_stall;
		shift_en = accept;
		issue.busy   = busy_q;
		issue.pass   = pass_q;
		issue.cursor = cursor_q;
		issue.eob    = at_end && last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pass_q   <= 1'b0;
			last_q   <= 1'b0;
			cursor_q <= '0;
			stop_q   <= '0;
			seen_q   <= '0;
		end else if (accept) begin
			last_q <= last;
			if (seen_q < SEEN_WINDOW) begin
				// short block: on the last sample, replay the held samples and the new one
				busy_q   <= last;
				pass_q   <= 1'b1;
				cursor_q <= CUR_W'(SEEN_WINDOW - seen_q);
				stop_q   <= CELL_NEWEST;
			end else begin
				busy_q   <= 1'b1;
				pass_q   <= 1'b0;
				cursor_q <= (seen_q == SEEN_WINDOW) ? POS_EDGE0 : POS_MID;
				stop_q   <= last ? POS_EDGE4 : POS_MID;
			end
			if (last) begin
				seen_q <= '0;
			end else if (seen_q < SEEN_FULL) begin
				seen_q <= seen_q + SEEN_W'(1);
			end
		end else if (busy_q && adv) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				cursor_q <= cursor_q + CUR_W'(1);
			end
		end
	end

	`FPSF_ASSERT_NOW(a_seen_range, 1'b1, seen_q <= SEEN_FULL)
	`FPSF_ASSERT_NOW(a_cursor_bound, busy_q, cursor_q <= stop_q)
	`FPSF_ASSERT_NEXT(a_last_bursts, accept && last, busy_q && seen_q == '0)
	`FPSF_ASSERT_NEXT(a_early_quiet, accept && !last && seen_q < SEEN_WINDOW, !busy_q)

endmodule

[rtl/core/fpsf_round.sv]
// ----------------------------------------------------------------------------
// fpsf_round
// Tap sum, round to nearest, divide by 35/70 or pass, saturate, output register
// ----------------------------------------------------------------------------
module fpsf_round (
	input  logic              clk,
	input  logic              arst_n,
	input  fpsf_pkg::ctrl_t   ctrl_in,
	input  fpsf_pkg::num_t    prod [fpsf_pkg::NUM_CELLS],
	input  logic              out_stall,
	output logic              adv,
	output logic              out_valid,
	output fpsf_pkg::sample_t smoothed,
	output logic              end_of_block
);
	import fpsf_pkg::*;

	ctrl_t ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	num_t  num_s2;
	logic  neg_s3, neg_s4;
	logic [MAG_W-1:0]  x_s3, x_s4;
	logic [PROD_W-1:0] prod_s4;

	logic              out_valid_q;
	logic              eob_q;
	sample_t           smoothed_q;

	num_t              abs_v;
	logic [MAG_W-1:0]  half;
	logic [MAG_W-1:0]  mag;
	logic [MAG_W-1:0]  x_next;
	logic [RECIP_W-1:0] q_est;
	logic [MAG_W-1:0]  rem;
	logic [MAG_W-1:0]  qmag;
	logic [MAG_W-1:0]  qneg;
	sample_t           sat_v;

	assign adv = !out_valid_q || !out_stall;

	always_comb begin
		abs_v = num_s2[NUM_W-1] ? -num_s2 : num_s2;
		case (ctrl_s2.den)
			DEN_35:  half = MAG_W'(HALF_35);
			DEN_70:  half = MAG_W'(HALF_70);
			default: half = '0;
		endcase
		mag = abs_v[MAG_W-1:0] + half;
		// divide by 70 as halve, then divide by 35
		x_next = (ctrl_s2.den == DEN_70) ? (mag >> 1) : mag;
	end

	always_comb begin
		q_est = prod_s4[PROD_W-1:MAG_W];
		rem   = x_s4 - MAG_W'(q_est) * MAG_W'(DIVISOR);
		if (ctrl_s4.den == DEN_ONE) begin
			qmag = x_s4;
		end else if (rem >= MAG_W'(DIVISOR)) begin
			qmag = MAG_W'(q_est) + MAG_W'(1);
		end else begin
			qmag = MAG_W'(q_est);
		end
		qneg = -qmag;
		if (neg_s4) begin
			sat_v = (qmag > MAG_NEG_MAX) ? SAMPLE_MIN : sample_t'(qneg[SAMPLE_WIDTH-1:0]);
		end else begin
			sat_v = (qmag > MAG_POS_MAX) ? SAMPLE_MAX : sample_t'(qmag[SAMPLE_WIDTH-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1     <= '0;
			ctrl_s2     <= '0;
			ctrl_s3     <= '0;
			ctrl_s4     <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			ctrl_s1     <= ctrl_in;
			ctrl_s2     <= ctrl_s1;
			ctrl_s3     <= ctrl_s2;
			ctrl_s4     <= ctrl_s3;
			out_valid_q <= ctrl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2     <= prod[0] + prod[1] + prod[2] + prod[3] + prod[4];
			neg_s3     <= num_s2[NUM_W-1];
			x_s3       <= x_next;
			neg_s4     <= neg_s3;
			x_s4       <= x_s3;
			prod_s4    <= PROD_W'(x_s3) * PROD_W'(RECIP_35);
			smoothed_q <= sat_v;
			eob_q      <= ctrl_s4.eob;
		end
	end

	assign out_valid    = out_valid_q;
	assign smoothed     = smoothed_q;
	assign end_of_block = eob_q;

endmodule

[rtl/core/five_point_smoothing_filter_core.sv]
// ----------------------------------------------------------------------------
// five_point_smoothing_filter_core
// Five-point quadratic least-squares smoothing of sample blocks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  input   | in        | in_valid / in_stall  | sample[15:0] signed, last
//  output  | out       | out_valid / out_stall| smoothed[15:0] signed,
//          |           |                      | end_of_block
//
//  One sample is taken per cycle while each sample yields at most one result
//  and the output is not stalled. A sample that yields k results holds
//  in_stall until the last one issues: the burst sequencer feeds the shared
//  rounding pipeline one result per cycle while it advances. Results pass the
//  product, tap-sum, rounding, reciprocal-product and output registers. Reset
//  clears the window cells to zero and the block position to its start. A
//  stalled valid output freezes the whole pipeline; the window never moves
//  under a stall unless the sample transfer itself completes.
// ----------------------------------------------------------------------------
module five_point_smoothing_filter_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  fpsf_pkg::sample_t sample,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output fpsf_pkg::sample_t smoothed,
	output logic              end_of_block
);
	import fpsf_pkg::*;

	logic    adv;
	logic    shift_en;
	issue_t  issue;
	ctrl_t   ctrl_in;

	sample_t held     [NUM_CELLS];
	sample_t shift_in [NUM_CELLS];
	coef_t   coef     [NUM_CELLS];
	num_t    prod     [NUM_CELLS];

	// Sequencer: tracks how far into the block we are and walks the results
	// that the last accepted sample owes, one per pipeline advance.
	fpsf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.adv      (adv),
		.in_stall (in_stall),
		.shift_en (shift_en),
		.issue    (issue)
	);

	// Window: cell 0 holds the oldest sample, cell 4 the newest. Each
	// transfer moves every sample one cell toward cell 0.
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		if (i == NUM_CELLS - 1) begin : g_head
			assign shift_in[i] = sample;
		end else begin : g_body
			assign shift_in[i] = held[i+1];
		end

		// tap for this cell at the current burst position
		assign coef[i] = tap_coef(issue.pass, issue.cursor, CUR_W'(i));

		fpsf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (shift_en),
			.adv       (adv),
			.sample_in (shift_in[i]),
			.coef      (coef[i]),
			.held      (held[i]),
			.prod      (prod[i])
		);
	end

	// Divisor and block-end flag travel with each issued result.
	always_comb begin
		ctrl_in.valid = issue.busy;
		ctrl_in.den   = den_of(issue.pass, issue.cursor);
		ctrl_in.eob   = issue.eob;
	end

	// Sum, round, divide, saturate, then hold in the output register.
	fpsf_round u_round (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl_in      (ctrl_in),
		.prod         (prod),
		.out_stall    (out_stall),
		.adv          (adv),
		.out_valid    (out_valid),
		.smoothed     (smoothed),
		.end_of_block (end_of_block)
	);

endmodule

[test/five_point_smoothing_filter_core_tb.sv]
// ----------------------------------------------------------------------------
// five_point_smoothing_filter_core_tb
// Self-checking bench for the five-point smoothing core. Blocks of samples are
// sent over the valid/stall input, each transfer is run through a local model
// of the least-squares filter, and every output transfer is compared against
// the oldest predicted result. Both sides idle at random in two phases, and
// one stretch holds the output off long enough to back the core up.
// ----------------------------------------------------------------------------
module five_point_smoothing_filter_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import fpsf_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 80;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		sample_t value;
		logic    eob;
	} smooth_result_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	sample_t sample;
	logic    last;
	logic    out_valid;
	logic    out_stall = 1'b0;
	sample_t smoothed;
	logic    end_of_block;

	// Local copy of the filter state: the four newest samples (index 3 newest)
	// and how many samples of the current block have been taken, capped at 5.
	sample_t        held_samples [4];
	int             block_fill;
	smooth_result_t expected_results [$];

	int  send_idle_pct;
	int  recv_idle_pct;
	logic hold_output = 1'b0;
	int  error_count;
	int  cycle_count;

	five_point_smoothing_filter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.smoothed     (smoothed),
		.end_of_block (end_of_block)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Round to nearest with ties away from zero, then clamp to the sample range.
	function automatic sample_t round_to_sample(longint num, longint den);
		longint q;
		if (num >= 0) begin
			q = (num + den / 2) / den;
		end else begin
			q = -((-num + den / 2) / den);
		end
		if (q > longint'(SAMPLE_MAX)) q = longint'(SAMPLE_MAX);
		if (q < longint'(SAMPLE_MIN)) q = longint'(SAMPLE_MIN);
		return sample_t'(q);
	endfunction

	function automatic void queue_result(sample_t value, logic eob);
		smooth_result_t r;
		r.value = value;
		r.eob   = eob;
		expected_results.push_back(r);
	endfunction

	// Work out what one accepted sample produces and advance the local state.
	function automatic void predict_smoothing(sample_t s, logic is_last);
		longint a, b, c, d, e;
		int     i;
		a = longint'(held_samples[0]);
		b = longint'(held_samples[1]);
		c = longint'(held_samples[2]);
		d = longint'(held_samples[3]);
		e = longint'(s);
		if (block_fill < 4) begin
			// Short block: release the held samples of this block untouched.
			if (is_last) begin
				for (i = 4 - block_fill; i < 4; i++)
					queue_result(held_samples[i], 1'b0);
				queue_result(s, 1'b1);
			end
		end else begin
			if (block_fill == 4) begin
				queue_result(round_to_sample(69*a + 4*b - 6*c + 4*d - e, 70), 1'b0);
				queue_result(round_to_sample(2*a + 27*b + 12*c - 8*d + 2*e, 35), 1'b0);
			end
			queue_result(round_to_sample(-3*a + 12*b + 17*c + 12*d - 3*e, 35), 1'b0);
			if (is_last) begin
				queue_result(round_to_sample(2*a - 8*b + 12*c + 27*d + 2*e, 35), 1'b0);
				queue_result(round_to_sample(-a + 4*b - 6*c + 4*d + 69*e, 70), 1'b1);
			end
		end
		held_samples[0] = held_samples[1];
		held_samples[1] = held_samples[2];
		held_samples[2] = held_samples[3];
		held_samples[3] = s;
		if (is_last) block_fill = 0;
		else if (block_fill < 5) block_fill++;
	endfunction

	function automatic void flag_error(string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Offer one sample and return at the edge where it transfers. Valid is left
	// high so back-to-back samples go out without a bubble; idling lowers it.
	task automatic send_sample(sample_t s, logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		last     <= is_last;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_smoothing(s, is_last);
	endtask

	// Bias toward the rails and small values, but keep full-range draws so
	// every bit of the sample toggles.
	function automatic sample_t pick_sample();
		sample_t s;
		case ($urandom_range(9))
			0: s = SAMPLE_MAX;
			1: s = SAMPLE_MIN;
			2: s = sample_t'(SAMPLE_MAX - sample_t'($urandom_range(300)));
			3: s = sample_t'(SAMPLE_MIN + sample_t'($urandom_range(300)));
			4, 5: s = sample_t'(int'($urandom_range(400)) - 200);
			default: s = sample_t'($urandom);
		endcase
		return s;
	endfunction

	// Pass-through blocks of one to four samples, each sample distinct so
	// ordering errors show.
	task automatic test_short_blocks();
		int len, j;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (len = 1; len <= 4; len++)
			for (j = 0; j < len; j++)
				send_sample(sample_t'(len * 100 + j), j == len - 1);
	endtask

	// Full-scale alternation drives every tap with rail inputs; a constant
	// rail block checks that the edge fits land exactly on the rail.
	task automatic test_extremes();
		int j;
		for (j = 0; j < 5; j++)
			send_sample((j % 2) ? SAMPLE_MIN : SAMPLE_MAX, j == 4);
		for (j = 0; j < 6; j++)
			send_sample((j % 2) ? SAMPLE_MAX : SAMPLE_MIN, j == 5);
		for (j = 0; j < 5; j++)
			send_sample(SAMPLE_MIN, j == 4);
	endtask

	// Random blocks: mostly the normal smoothing path, some short pass-through
	// blocks and a few long ones.
	task automatic test_random_blocks(int send_pct, int recv_pct, int item_target);
		int sent, len, j;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < item_target) begin
			case ($urandom_range(9))
				0, 1: len = $urandom_range(4, 1);
				2: len = $urandom_range(50, 20);
				default: len = $urandom_range(12, 5);
			endcase
			for (j = 0; j < len; j++)
				send_sample(pick_sample(), j == len - 1);
			sent += len;
		end
	endtask

	// Hold the output off while a long block keeps coming, so the pipeline
	// fills and the core must stall its input.
	task automatic test_output_hold();
		int j;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				hold_output <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output <= 1'b0;
			end
			for (j = 0; j < 30; j++)
				send_sample(pick_sample(), j == 29);
		join
	endtask

	// Receiver: stall at random, or solidly during a hold.
	always @(posedge clk)
		out_stall <= hold_output || ($urandom_range(99) < recv_idle_pct);

	// Checker: compare each output transfer with the oldest expectation.
	always @(posedge clk) begin
		smooth_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				flag_error($sformatf("unexpected result smoothed=%0d end_of_block=%b",
					smoothed, end_of_block));
			end else begin
				want = expected_results.pop_front();
				if (smoothed !== want.value)
					flag_error($sformatf("smoothed: expected %0d, got %0d",
						want.value, smoothed));
				if (end_of_block !== want.eob)
					flag_error($sformatf("end_of_block: expected %b, got %b",
						want.eob, end_of_block));
			end
		end
	end

	// Watchdog: give up well past the slowest legal run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		sample        = '0;
		last          = 1'b0;
		error_count   = 0;
		cycle_count   = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		block_fill    = 0;
		for (int i = 0; i < 4; i++) held_samples[i] = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_blocks();
		test_extremes();
		test_random_blocks(16, 82, 85);
		test_random_blocks(82, 16, 85);
		test_output_hold();
		test_random_blocks(0, 0, 85);

		// Stop offering, let every expected result drain, then watch a while
		// longer for stray output.
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
